FILE: rtl/nad_pkg.sv
package nad_pkg;

   // format codes carried on req_tuser
   typedef enum logic [2:0] {
      FMT_HEX8  = 3'd0,
      FMT_HEX16 = 3'd1,
      FMT_HEX32 = 3'd2,
      FMT_DEC8  = 3'd3,
      FMT_DEC16 = 3'd4,
      FMT_DEC32 = 3'd5,
      FMT_NOTE  = 3'd6
   } fmt_type;

   localparam int unsigned MAX_DIGIT = 11;

   localparam logic [29:0] POW10 [10] = '{
      30'd1, 30'd10, 30'd100, 30'd1000, 30'd10000, 30'd100000, 30'd1000000,
      30'd10000000, 30'd100000000, 30'd1000000000
   };

   // number of digits per format, zero for the unused code
   function automatic logic [3:0] digit_count(fmt_type f);
      case (f)
         FMT_HEX8:  digit_count = 4'd2;
         FMT_HEX16: digit_count = 4'd4;
         FMT_HEX32: digit_count = 4'd8;
         FMT_DEC8:  digit_count = 4'd3;
         FMT_DEC16: digit_count = 4'd5;
         FMT_DEC32: digit_count = 4'd10;
         FMT_NOTE:  digit_count = 4'd2;
         default:   digit_count = 4'd0;
      endcase
   endfunction

   function automatic logic is_hex(fmt_type f);
      case (f)
         FMT_HEX8, FMT_HEX16, FMT_HEX32: is_hex = 1'b1;
         default:                        is_hex = 1'b0;
      endcase
   endfunction

   // place value of the digit at exponent e, decimal or base 12
   function automatic logic [31:0] digit_weight(fmt_type f, logic [3:0] e);
      if (f == FMT_NOTE) begin
         digit_weight = (e == 4'd0) ? 32'd1 : 32'd12;
      end else if (e > 4'd9) begin
         digit_weight = 32'd0;
      end else begin
         digit_weight = {2'b00, POW10[e]};
      end
   endfunction

   function automatic logic [6:0] ascii_of(logic [3:0] d);
      if (d < 4'd10) begin
         ascii_of = 7'd48 + {3'b000, d};
      end else begin
         ascii_of = 7'd55 + {3'b000, d};
      end
   endfunction

endpackage

FILE: rtl/number_to_ascii_digits.sv
// number_to_ascii_digits: each input transaction carries a format code on req_tuser
// and a 32-bit unsigned number on req_tdata; the block returns the zero-padded
// ascii digits of the number, most significant first, one output transaction per
// digit, with rsp_tlast on the final one. hex8/16/32 give 2/4/8 upper-case hex
// digits, dec8/16/32 give 3/5/10 decimal digits, the note format gives two base-12
// digits ('0'-'9','A','B') of the low byte; 8- and 16-bit formats ignore the upper
// bits, and format code 7 is accepted and returns nothing. the digit engine produces
// one digit per cycle into the output register unless rsp_tready stalls it, by one
// compare-and-subtract step against the place value (a shift of the remainder for
// hex). the next number waits in a holding register and enters the engine in the
// cycle its predecessor's last digit is produced, so numbers follow with no gap;
// a number passes the holding and engine registers before the output register.
module number_to_ascii_digits (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // number
   input  logic [2:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // digit_char [6:0], digit_position [10:7], zero pad
   output logic        rsp_tlast    // last
);
   import nad_pkg::*;

   // holding register for the next number
   logic        hold_valid_ff, hold_valid_in;
   fmt_type     hold_fmt_ff, hold_fmt_in;
   logic [31:0] hold_num_ff, hold_num_in;

   // digit engine
   logic        active_ff, active_in;
   fmt_type     fmt_ff, fmt_in;
   logic [31:0] rem_ff, rem_in;
   logic [3:0]  pos_ff, pos_in;
   logic [3:0]  exp_ff, exp_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [6:0]  rsp_char_ff, rsp_char_in;
   logic [3:0]  rsp_pos_ff, rsp_pos_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        req_take;
   logic        out_free;
   logic        step;
   logic        step_last;
   logic        load_engine;
   logic [31:0] load_num;
   logic [3:0]  load_count;
   logic [31:0] weight;
   logic [35:0] mult [MAX_DIGIT + 1];
   logic [3:0]  dec_digit;
   logic [31:0] dec_sub;
   logic [3:0]  hex_digit;
   logic [3:0]  digit;

   // handshake and sequencing
   assign req_take    = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign step        = active_ff && out_free;
   assign step_last   = step && (exp_ff == 4'd0);
   assign load_engine = hold_valid_ff && (!active_ff || step_last);
   assign req_tready  = !hold_valid_ff || load_engine;

   // truncate to the format width; note digits work on the byte modulo 144
   always_comb begin
      case (hold_fmt_ff)
         FMT_HEX8, FMT_DEC8:   load_num = {24'd0, hold_num_ff[7:0]};
         FMT_HEX16, FMT_DEC16: load_num = {16'd0, hold_num_ff[15:0]};
         FMT_NOTE: begin
            if (hold_num_ff[7:0] >= 8'd144) begin
               load_num = {24'd0, hold_num_ff[7:0] - 8'd144};
            end else begin
               load_num = {24'd0, hold_num_ff[7:0]};
            end
         end
         default:              load_num = hold_num_ff;
      endcase
      load_count = digit_count(hold_fmt_ff);
   end

   // multiples of the current place value
   assign weight = digit_weight(fmt_ff, exp_ff);

   always_comb begin
      for (int m = 0; m <= MAX_DIGIT; m++) begin
         mult[m] = {4'd0, weight} * 36'(m);
      end
   end

   // the remainder stays below radix times the place value, so the digit is
   // the largest multiple not above it
   always_comb begin
      dec_digit = 4'd0;
      dec_sub   = 32'd0;
      for (int m = 1; m <= MAX_DIGIT; m++) begin
         if ({4'd0, rem_ff} >= mult[m]) begin
            dec_digit = 4'(m);
            dec_sub   = mult[m][31:0];
         end
      end
   end

   assign hex_digit = 4'(rem_ff >> {exp_ff[2:0], 2'b00});
   assign digit     = is_hex(fmt_ff) ? hex_digit : dec_digit;

   // next-state logic
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_fmt_in   = hold_fmt_ff;
      hold_num_in   = hold_num_ff;
      if (req_take) begin
         hold_valid_in = 1'b1;
         hold_fmt_in   = fmt_type'(req_tuser);
         hold_num_in   = req_tdata;
      end else if (load_engine) begin
         hold_valid_in = 1'b0;
      end

      active_in = active_ff;
      fmt_in    = fmt_ff;
      rem_in    = rem_ff;
      pos_in    = pos_ff;
      exp_in    = exp_ff;
      if (load_engine) begin
         active_in = (load_count != 4'd0);
         fmt_in    = hold_fmt_ff;
         rem_in    = load_num;
         pos_in    = 4'd0;
         exp_in    = load_count - 4'd1;
      end else if (step) begin
         active_in = (exp_ff != 4'd0);
         rem_in    = is_hex(fmt_ff) ? rem_ff : rem_ff - dec_sub;
         pos_in    = pos_ff + 4'd1;
         exp_in    = exp_ff - 4'd1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = ascii_of(digit);
         rsp_pos_in   = pos_ff;
         rsp_last_in  = (exp_ff == 4'd0);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         active_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_fmt_ff <= hold_fmt_in;
      hold_num_ff <= hold_num_in;
      fmt_ff      <= fmt_in;
      rem_ff      <= rem_in;
      pos_ff      <= pos_in;
      exp_ff      <= exp_in;
      rsp_char_ff <= rsp_char_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_pos_ff, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // decimal remainder must stay below ten times the place value
   a_dec_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (active_ff && (fmt_ff == FMT_DEC8 || fmt_ff == FMT_DEC16 || fmt_ff == FMT_DEC32))
      |-> ({4'd0, rem_ff} < mult[10]))
      else $error("decimal remainder out of range");

   // position and exponent always add up to the digit count less one
   a_pos_exp: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> ((5'(pos_ff) + 5'(exp_ff)) == (5'(digit_count(fmt_ff)) - 5'd1)))
      else $error("digit position and exponent disagree");

   // after a non-final digit leaves, more digits of that number are pending
   a_no_lost_digit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (active_ff || rsp_tvalid))
      else $error("digits of a number went missing");
`endif

endmodule
